[src/mced_pkg.sv]
// Package for the multi-channel event debouncer.
// Field widths, register constants, event codes and the per-channel state entry.
// No dependencies.
package mced_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CH_W             = 3;
    localparam int HOLD_W           = 8;
    localparam int HOLD_REGS        = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = HOLD_W;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd10;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } edge_code_t;

    // One entry of the channel state memory.
    typedef struct packed {
        logic              level;
        logic [HOLD_W-1:0] count;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);

endpackage

[src/mced_if.sv]
// Valid/ready channel interfaces for samples and debounce results.
// Depends on mced_pkg for field widths.
interface mced_sample_if;
    logic                       valid;
    logic                       ready;
    logic [mced_pkg::CH_W-1:0]  channel;
    logic                       raw_level;

    modport source (output valid, output channel, output raw_level, input ready);
    modport sink   (input valid, input channel, input raw_level, output ready);
endinterface

interface mced_result_if;
    logic                       valid;
    logic                       ready;
    logic [mced_pkg::CH_W-1:0]  channel_out;
    logic [1:0]                 edge_event;
    logic                       stable_level;

    modport source (output valid, output channel_out, output edge_event,
                    output stable_level, input ready);
    modport sink   (input valid, input channel_out, input edge_event,
                    input stable_level, output ready);
endinterface

[src/mced_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mced_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

[src/multi_channel_event_debouncer.sv]
// Top level of the multi-channel event debouncer.
// Depends on mced_pkg, mced_sample_if, mced_result_if and mced_ram.
//
// Takes one raw sample per clock on sample_ch while result_ch is not stalling,
// and returns one result per sample on result_ch, in order. The accepting
// edge clocks the read of the channel's level and counter from the state RAM
// into the read stage; when that stage advances, the state is updated, written
// back and loaded into the output register. Back-to-back samples of the same
// channel are forwarded from the last write, so any channel order runs at one
// sample per cycle while result_ch keeps taking results. Valid bits per
// channel make the state read as zero after reset, so no clearing pass is
// needed. Hold times must be written through cfg_we/cfg_index/cfg_wdata only
// while no sample is in flight; the block does not enforce this.
module multi_channel_event_debouncer #(
    parameter int NUM_CHANNELS = mced_pkg::NUM_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mced_sample_if.sink                       sample_ch,
    mced_result_if.source                     result_ch,
    input  logic                              cfg_we,
    input  logic [mced_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mced_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(NUM_CHANNELS);

    logic [mced_pkg::HOLD_W-1:0] hold_reg [mced_pkg::HOLD_REGS];
    logic [NUM_CHANNELS-1:0]     init_reg;

    // read stage
    logic                        s1_valid_reg;
    logic [mced_pkg::CH_W-1:0]   s1_ch_reg;
    logic                        s1_raw_reg;
    logic                        s1_init_reg;
    logic                        s1_inrange_reg;

    // last write, for read-after-write on the same channel
    logic                        fwd_valid_reg;
    logic [AW-1:0]               fwd_addr_reg;
    mced_pkg::chan_entry_t       fwd_data_reg;

    // output register
    logic                        out_valid_reg;
    logic [mced_pkg::CH_W-1:0]   out_ch_reg;
    mced_pkg::edge_code_t        out_edge_reg;
    logic                        out_level_reg;

    logic                        in_accept;
    logic                        s1_adv;
    logic                        in_range;
    logic                        ram_we;
    logic [AW-1:0]               s1_addr;
    logic [mced_pkg::ENTRY_W-1:0] ram_rd;
    mced_pkg::chan_entry_t       cur;
    mced_pkg::chan_entry_t       upd;
    mced_pkg::edge_code_t        edge_next;
    logic                        level_next;
    logic [mced_pkg::HOLD_W-1:0] hold_sel;
    logic [mced_pkg::HOLD_W-1:0] cnt_dec;

    assign in_accept       = sample_ch.valid && sample_ch.ready;
    assign s1_adv          = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !s1_valid_reg || s1_adv;
    assign in_range        = {1'b0, sample_ch.channel} < (mced_pkg::CH_W + 1)'(NUM_CHANNELS);
    assign s1_addr         = s1_ch_reg[AW-1:0];
    assign ram_we          = s1_adv && s1_inrange_reg;

    mced_ram #(
        .WIDTH (mced_pkg::ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s1_addr),
        .wr_data (upd),
        .rd_en   (in_accept && in_range),
        .rd_addr (sample_ch.channel[AW-1:0]),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur = fwd_data_reg;
        end
        else if (s1_init_reg)
        begin
            cur = mced_pkg::chan_entry_t'(ram_rd);
        end
        else
        begin
            cur = '0;
        end

        hold_sel   = hold_reg[s1_ch_reg];
        cnt_dec    = cur.count - 1'b1;
        upd        = cur;
        edge_next  = mced_pkg::EV_NONE;

        if (s1_raw_reg != cur.level)
        begin
            if (cur.count == '0)
            begin
                upd.count = hold_sel;
            end
            else
            begin
                upd.count = cnt_dec;
                if (cnt_dec == '0)
                begin
                    upd.level = s1_raw_reg;
                    edge_next = s1_raw_reg ? mced_pkg::EV_RISE : mced_pkg::EV_FALL;
                end
            end
        end
        else
        begin
            upd.count = '0;
        end

        // channels beyond the configured count leave state alone and report zero
        if (!s1_inrange_reg)
        begin
            edge_next = mced_pkg::EV_NONE;
        end
        level_next = s1_inrange_reg && upd.level;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            init_reg      <= '0;
            for (int i = 0; i < mced_pkg::HOLD_REGS; i++)
            begin
                hold_reg[i] <= mced_pkg::HOLD_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                hold_reg[cfg_index] <= cfg_wdata;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                fwd_valid_reg     <= 1'b1;
                init_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ch_reg      <= sample_ch.channel;
            s1_raw_reg     <= sample_ch.raw_level;
            s1_inrange_reg <= in_range;
            s1_init_reg    <= in_range && init_reg[sample_ch.channel[AW-1:0]];
        end
        if (ram_we)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= upd;
        end
        if (s1_adv)
        begin
            out_ch_reg    <= s1_ch_reg;
            out_edge_reg  <= edge_next;
            out_level_reg <= level_next;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.channel_out  = out_ch_reg;
    assign result_ch.edge_event   = out_edge_reg;
    assign result_ch.stable_level = out_level_reg;

endmodule
